>>> rtl/lprt_pkg.sv
// Shared types and constants for the longest-prefix route table.
// Holds the route entry layout, operation and result codes, the controller
// states and the command and status structs between controller and datapath.
package lprt_pkg;

	localparam int ADDR_BITS = 32;
	localparam int LEN_BITS  = 6;
	localparam int MAC_BITS  = 48;

	localparam logic [LEN_BITS-1:0] MIN_LEN = 6'd2;
	localparam logic [LEN_BITS-1:0] MAX_LEN = 6'd32;

	typedef enum logic [1:0] {
		ACT_LOOKUP = 2'd0,
		ACT_ADD    = 2'd1,
		ACT_DELETE = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_DUP      = 3'd1,
		ST_FULL     = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_BADLEN   = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_APPLY
	} state_t;

	typedef struct packed {
		logic                vld;
		logic [LEN_BITS-1:0] len;
		logic [ADDR_BITS-1:0] addr;
		logic [MAC_BITS-1:0] mac;
	} route_t;

	typedef struct packed {
		logic clear_wr;
		logic scan_rd;
		logic capture;
		logic apply;
	} ctrl_cmd_t;

	typedef struct packed {
		logic last_idx;
		logic out_free;
	} ctrl_sts_t;

	function automatic logic len_ok(input logic [LEN_BITS-1:0] len);
		return (len >= MIN_LEN) && (len <= MAX_LEN);
	endfunction

endpackage

>>> rtl/longest_prefix_route_table_unit.sv
// Longest-prefix IPv4 route table: lookup, add and delete over ROUTES slots.
// An item is taken only in idle; the scan state reads every slot, then drain and
// apply follow. The single RAM read port scans one slot a cycle.
// The result register lets the next item enter while a result waits.
// After reset a clearing pass over all ROUTES slots empties the table; in_stall
// stays high until it ends.
module longest_prefix_route_table_unit #(
	parameter int ROUTES = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     action,
	input  logic [lprt_pkg::ADDR_BITS-1:0] address,
	input  logic [lprt_pkg::LEN_BITS-1:0]  prefix_len,
	input  logic [lprt_pkg::MAC_BITS-1:0]  mac,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           hit,
	output logic [lprt_pkg::MAC_BITS-1:0]  mac_out,
	output logic [2:0]                     status
);

	import lprt_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	lprt_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	lprt_dpath #(
		.ROUTES(ROUTES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.action    (action),
		.address   (address),
		.prefix_len(prefix_len),
		.mac       (mac),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.hit       (hit),
		.mac_out   (mac_out),
		.status    (status)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("Input was not stalled after an item was accepted.");

	a_hit_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hit) |-> (status == ST_OK))
		else $error("A hit was reported with a non-ok status.");

	a_update_no_mac: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != ST_OK)) |-> (!hit && (mac_out == '0)))
		else $error("An update result carried a hit or a MAC.");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status <= ST_BADLEN))
		else $error("Result status code out of range.");

endmodule

>>> rtl/lprt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; holds the route entries of the table.
module lprt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic                                 re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/lprt_ctrl.sv
// Controller state machine of the route table: clearing pass, table scan
// and result hand-off. Uses lprt_pkg; drives the datapath by command struct.
module lprt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  lprt_pkg::ctrl_sts_t sts,
	output lprt_pkg::ctrl_cmd_t cmd
);

	import lprt_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: if (sts.last_idx) state_d = S_IDLE;
			S_IDLE:  if (in_valid) state_d = S_SCAN;
			S_SCAN:  if (sts.last_idx) state_d = S_DRAIN;
			S_DRAIN: state_d = S_APPLY;
			S_APPLY: if (sts.out_free) state_d = S_IDLE;
			default: state_d = S_CLEAR;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_CLEAR: cmd.clear_wr = 1'b1;
			S_IDLE: begin
				in_stall = 1'b0;
				cmd.capture = in_valid;
			end
			S_SCAN:  cmd.scan_rd = 1'b1;
			S_DRAIN: cmd = '0;
			S_APPLY: cmd.apply = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

>>> rtl/lprt_dpath.sv
// Datapath of the route table: item registers, slot counter, route RAM,
// scan accumulators, update decision and result register.
// Uses lprt_pkg and lprt_ram; commanded by lprt_ctrl.
module lprt_dpath #(
	parameter int ROUTES = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  lprt_pkg::ctrl_cmd_t                 cmd,
	output lprt_pkg::ctrl_sts_t                 sts,
	input  logic [1:0]                          action,
	input  logic [lprt_pkg::ADDR_BITS-1:0]      address,
	input  logic [lprt_pkg::LEN_BITS-1:0]       prefix_len,
	input  logic [lprt_pkg::MAC_BITS-1:0]       mac,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                hit,
	output logic [lprt_pkg::MAC_BITS-1:0]       mac_out,
	output logic [2:0]                          status
);

	import lprt_pkg::*;

	localparam int IW = (ROUTES > 1) ? $clog2(ROUTES) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(ROUTES - 1);

	logic [1:0]           act_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [LEN_BITS-1:0]  len_q;
	logic [MAC_BITS-1:0]  mac_q;
	logic [IW-1:0]        idx_q;
	logic                 pv_s1;
	logic [IW-1:0]        pidx_s1;

	logic [LEN_BITS-1:0]  best_len_q;
	logic                 hit_acc_q;
	logic [MAC_BITS-1:0]  best_mac_q;
	logic                 ex_found_q;
	logic [IW-1:0]        ex_slot_q;
	logic                 ex_maceq_q;
	logic                 fr_found_q;
	logic [IW-1:0]        fr_slot_q;

	logic                 ov_q;
	logic                 hit_q;
	logic [MAC_BITS-1:0]  mac_out_q;
	status_t              status_q;

	logic [$bits(route_t)-1:0] rdata;
	route_t               rd;
	logic [ADDR_BITS-1:0] len_mask;
	logic                 pfx_match;

	logic                 upd_we;
	logic [IW-1:0]        upd_slot;
	route_t               upd_entry;
	logic                 res_hit;
	logic [MAC_BITS-1:0]  res_mac;
	status_t              res_status;
	logic                 len_good;

	logic                 ram_we;
	logic [IW-1:0]        ram_waddr;
	route_t               ram_wdata;

	assign sts.last_idx = (idx_q == LAST_IDX);
	assign sts.out_free = !ov_q || !out_stall;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q  <= action;
			addr_q <= address;
			len_q  <= prefix_len;
			mac_q  <= mac;
		end
		pidx_s1 <= idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			pv_s1 <= 1'b0;
		end else begin
			pv_s1 <= cmd.scan_rd;
			if (cmd.capture) begin
				idx_q <= '0;
			end else if (cmd.clear_wr || cmd.scan_rd) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	assign ram_we    = cmd.clear_wr || upd_we;
	assign ram_waddr = cmd.clear_wr ? idx_q : upd_slot;
	assign ram_wdata = cmd.clear_wr ? route_t'('0) : upd_entry;

	lprt_ram #(
		.WIDTH($bits(route_t)),
		.DEPTH(ROUTES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.scan_rd),
		.raddr(idx_q),
		.rdata(rdata)
	);

	assign rd        = route_t'(rdata);
	assign len_mask  = {ADDR_BITS{1'b1}} << (MAX_LEN - rd.len);
	assign pfx_match = ((rd.addr ^ addr_q) & len_mask) == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_len_q <= '0;
			hit_acc_q  <= 1'b0;
			best_mac_q <= '0;
			ex_found_q <= 1'b0;
			ex_slot_q  <= '0;
			ex_maceq_q <= 1'b0;
			fr_found_q <= 1'b0;
			fr_slot_q  <= '0;
		end else if (cmd.capture) begin
			best_len_q <= '0;
			hit_acc_q  <= 1'b0;
			best_mac_q <= '0;
			ex_found_q <= 1'b0;
			fr_found_q <= 1'b0;
		end else if (pv_s1) begin
			if (rd.vld && len_ok(rd.len) && pfx_match && (rd.len > best_len_q)) begin
				best_len_q <= rd.len;
				hit_acc_q  <= 1'b1;
				best_mac_q <= rd.mac;
			end
			if (!ex_found_q && rd.vld && (rd.addr == addr_q) && (rd.len == len_q)) begin
				ex_found_q <= 1'b1;
				ex_slot_q  <= pidx_s1;
				ex_maceq_q <= (rd.mac == mac_q);
			end
			if (!fr_found_q && !rd.vld) begin
				fr_found_q <= 1'b1;
				fr_slot_q  <= pidx_s1;
			end
		end
	end

	assign len_good = len_ok(len_q);

	always_comb begin
		upd_we     = 1'b0;
		upd_slot   = ex_slot_q;
		upd_entry  = '{vld: 1'b1, len: len_q, addr: addr_q, mac: mac_q};
		res_hit    = 1'b0;
		res_mac    = '0;
		res_status = ST_OK;
		unique case (act_q)
			ACT_LOOKUP: begin
				res_hit = hit_acc_q;
				res_mac = best_mac_q;
			end
			ACT_ADD: begin
				if (!len_good) begin
					res_status = ST_BADLEN;
				end else if (ex_found_q) begin
					if (ex_maceq_q) begin
						res_status = ST_DUP;
					end else begin
						upd_we = cmd.apply;
					end
				end else if (fr_found_q) begin
					upd_slot = fr_slot_q;
					upd_we   = cmd.apply;
				end else begin
					res_status = ST_FULL;
				end
			end
			ACT_DELETE: begin
				upd_entry = '0;
				if (!len_good) begin
					res_status = ST_BADLEN;
				end else if (ex_found_q) begin
					upd_we = cmd.apply;
				end else begin
					res_status = ST_NOTFOUND;
				end
			end
			default: res_status = ST_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.apply) begin
			ov_q <= 1'b1;
		end else if (!out_stall) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			hit_q     <= res_hit;
			mac_out_q <= res_mac;
			status_q  <= res_status;
		end
	end

	assign out_valid = ov_q;
	assign hit       = hit_q;
	assign mac_out   = mac_out_q;
	assign status    = status_q;

endmodule
